// ===== hdl/rbcr_pkg.sv =====
// Package for the ring buffer chunk reserve/commit pointer manager.
// Holds the widths, operation and status codes and the structs shared by the
// calculation module and the top level. Depends on nothing.
package rbcr_pkg;

    localparam int CAP_W = 17;
    localparam int PTR_W = 16;
    localparam int LEN_W = 17;

    localparam logic [CAP_W-1:0] MAX_CAPACITY = 17'd65536;
    localparam logic [CAP_W-1:0] MIN_CAPACITY = 17'd1;

    typedef enum logic [2:0] {
        OP_REQ_READ     = 3'd0,
        OP_COMMIT_READ  = 3'd1,
        OP_REQ_WRITE    = 3'd2,
        OP_COMMIT_WRITE = 3'd3,
        OP_TERMINATE    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_LENGTH = 3'd1,
        ST_TERMINATED  = 3'd2,
        ST_WOULD_BLOCK = 3'd3,
        ST_OVERRUN     = 3'd4
    } status_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [PTR_W-1:0] rd_ptr;
        logic [PTR_W-1:0] wr_ptr;
        logic             full;
        logic             stopped;
    } ring_state_t;

    typedef struct packed {
        status_t          status;
        logic [PTR_W-1:0] chunk_offset;
        logic [LEN_W-1:0] granted;
        logic [CAP_W-1:0] bytes_available;
        logic [CAP_W-1:0] bytes_free;
    } ring_result_t;

endpackage

// ===== hdl/rbcr_calc.sv =====
// Combinational evaluation of one ring operation against the pointer state.
// Produces the result word and the next pointer state; uses rbcr_pkg.
module rbcr_calc
    import rbcr_pkg::*;
(
    input  logic [2:0]       req_type,
    input  logic [LEN_W-1:0] length,
    input  ring_state_t      state,
    output ring_result_t     result,
    output ring_state_t      state_next
);

    logic [CAP_W-1:0] avail;
    logic [CAP_W-1:0] room;
    logic [CAP_W-1:0] avail_new;
    logic [CAP_W-1:0] rd_to_wrap;
    logic [CAP_W-1:0] wr_to_wrap;
    logic [CAP_W:0]   rd_sum;
    logic [CAP_W:0]   wr_sum;
    logic [CAP_W:0]   rd_wrapped;
    logic [CAP_W:0]   wr_wrapped;
    logic             len_zero;

    function automatic logic [CAP_W-1:0] min3(
        input logic [CAP_W-1:0] a,
        input logic [CAP_W-1:0] b,
        input logic [CAP_W-1:0] c
    );
        logic [CAP_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    always_comb
    begin
        if (state.rd_ptr == state.wr_ptr)
        begin
            avail = state.full ? state.capacity : '0;
        end
        else if (state.wr_ptr > state.rd_ptr)
        begin
            avail = {1'b0, state.wr_ptr} - {1'b0, state.rd_ptr};
        end
        else
        begin
            avail = {1'b0, state.wr_ptr} + state.capacity - {1'b0, state.rd_ptr};
        end
    end

    assign room       = state.capacity - avail;
    assign rd_to_wrap = state.capacity - {1'b0, state.rd_ptr};
    assign wr_to_wrap = state.capacity - {1'b0, state.wr_ptr};
    assign len_zero   = (length == '0);

    assign rd_sum = {2'b00, state.rd_ptr} + {1'b0, length};
    assign wr_sum = {2'b00, state.wr_ptr} + {1'b0, length};
    assign rd_wrapped = (rd_sum >= {1'b0, state.capacity}) ?
                        rd_sum - {1'b0, state.capacity} : rd_sum;
    assign wr_wrapped = (wr_sum >= {1'b0, state.capacity}) ?
                        wr_sum - {1'b0, state.capacity} : wr_sum;

    always_comb
    begin
        state_next            = state;
        result.status         = ST_OK;
        result.chunk_offset   = '0;
        result.granted        = '0;
        avail_new             = avail;

        unique case (req_type)
            OP_REQ_READ:
            begin
                if (len_zero)
                begin
                    result.status = ST_ZERO_LENGTH;
                end
                else if (state.stopped)
                begin
                    result.status = ST_TERMINATED;
                end
                else if (avail == '0)
                begin
                    result.status = ST_WOULD_BLOCK;
                end
                else
                begin
                    result.granted      = min3(avail, rd_to_wrap, length);
                    result.chunk_offset = state.rd_ptr;
                end
            end
            OP_COMMIT_READ:
            begin
                if (!len_zero)
                begin
                    if (avail < length)
                    begin
                        result.status = ST_OVERRUN;
                    end
                    else
                    begin
                        state_next.rd_ptr = rd_wrapped[PTR_W-1:0];
                        state_next.full   = 1'b0;
                        avail_new         = avail - length;
                    end
                end
            end
            OP_REQ_WRITE:
            begin
                if (len_zero)
                begin
                    result.status = ST_ZERO_LENGTH;
                end
                else if (state.stopped)
                begin
                    result.status = ST_TERMINATED;
                end
                else if (room == '0)
                begin
                    result.status = ST_WOULD_BLOCK;
                end
                else
                begin
                    result.granted      = min3(room, wr_to_wrap, length);
                    result.chunk_offset = state.wr_ptr;
                end
            end
            OP_COMMIT_WRITE:
            begin
                if (!len_zero)
                begin
                    if (room < length)
                    begin
                        result.status = ST_OVERRUN;
                    end
                    else
                    begin
                        state_next.wr_ptr = wr_wrapped[PTR_W-1:0];
                        state_next.full   = (room == length);
                        avail_new         = avail + length;
                    end
                end
            end
            OP_TERMINATE:
            begin
                state_next.stopped = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase

        result.bytes_available = avail_new;
        result.bytes_free      = state.capacity - avail_new;
    end

endmodule

// ===== hdl/ring_buffer_chunk_reserve_commit.sv =====
// A taken word is held in the input register; its result goes to the separate
// result register when the output advances. Throughput: one word per cycle when
// the receiver does not stall; a new word can still be taken while a result waits.
// The pointer update is a single compare-and-subtract wrap against the capacity.
// Reset: pointers, full and terminated flags cleared, capacity set to 65536.
// Top level of the ring pointer manager; uses rbcr_pkg and rbcr_calc.
module ring_buffer_chunk_reserve_commit
    import rbcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CAP_W-1:0] cfg_write_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [2:0]       req_type,
    input  logic [LEN_W-1:0] length,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [2:0]       status,
    output logic [PTR_W-1:0] chunk_offset,
    output logic [LEN_W-1:0] granted,
    output logic [CAP_W-1:0] bytes_available,
    output logic [CAP_W-1:0] bytes_free
);

    logic             in_valid_reg;
    logic [2:0]       in_type_reg;
    logic [LEN_W-1:0] in_len_reg;
    logic             out_valid_reg;
    ring_result_t     out_reg;
    ring_result_t     calc_result;
    ring_state_t      state_reg;
    ring_state_t      state_next;
    logic             advance;
    logic             item_take;
    logic [CAP_W-1:0] cap_clamped;

    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        if (cfg_write_data == '0)
        begin
            cap_clamped = MIN_CAPACITY;
        end
        else if (cfg_write_data > MAX_CAPACITY)
        begin
            cap_clamped = MAX_CAPACITY;
        end
        else
        begin
            cap_clamped = cfg_write_data;
        end
    end

    rbcr_calc u_calc (
        .req_type   (in_type_reg),
        .length     (in_len_reg),
        .state      (state_reg),
        .result     (calc_result),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{capacity: MAX_CAPACITY, rd_ptr: '0, wr_ptr: '0,
                               full: 1'b0, stopped: 1'b0};
        end
        else
        begin
            if (item_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end

            if (cfg_write_en)
            begin
                state_reg.capacity <= cap_clamped;
                state_reg.rd_ptr   <= '0;
                state_reg.wr_ptr   <= '0;
                state_reg.full     <= 1'b0;
            end
            else if (advance && in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_type_reg <= req_type;
            in_len_reg  <= length;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= calc_result;
        end
    end

    assign result_valid    = out_valid_reg;
    assign status          = out_reg.status;
    assign chunk_offset    = out_reg.chunk_offset;
    assign granted         = out_reg.granted;
    assign bytes_available = out_reg.bytes_available;
    assign bytes_free      = out_reg.bytes_free;

`ifndef ASSERT_OFF
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, state_reg.rd_ptr} < state_reg.capacity) &&
        ({1'b0, state_reg.wr_ptr} < state_reg.capacity))
        else $error("ring pointer at or beyond capacity");

    a_full_pointers_equal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.full |-> (state_reg.rd_ptr == state_reg.wr_ptr))
        else $error("ring marked full with differing pointers");

    a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(state_reg.stopped))
        else $error("terminated flag cleared without reset");

    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.granted != '0)) |-> (out_reg.status == ST_OK))
        else $error("chunk granted with a failing status");

    a_space_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.bytes_available + out_reg.bytes_free)
                           == state_reg.capacity))
        else $error("filled and free space do not add up to capacity");
`endif

endmodule

// ===== test/ring_buffer_chunk_reserve_commit_checker.sv =====
// Checker for the ring pointer manager: watches the configuration port and both word channels,
// predicts every result word from its own copy of the ring state and compares it field by field.
// Depends on rbcr_pkg for widths, operation and status codes and the result struct.
module ring_buffer_chunk_reserve_commit_checker
    import rbcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CAP_W-1:0] cfg_write_data,
    input  logic             item_valid,
    input  logic             item_stall,
    input  logic [2:0]       req_type,
    input  logic [LEN_W-1:0] length,
    input  logic             result_valid,
    input  logic             result_stall,
    input  logic [2:0]       status,
    input  logic [PTR_W-1:0] chunk_offset,
    input  logic [LEN_W-1:0] granted,
    input  logic [CAP_W-1:0] bytes_available,
    input  logic [CAP_W-1:0] bytes_free,
    output int               mismatches,
    output int               outstanding
);

    int           ring_size;
    int           rd_pos;
    int           wr_pos;
    logic         is_full;
    logic         is_stopped;
    ring_result_t pending_results[$];
    ring_result_t fresh_outcome;
    ring_result_t oldest_outcome;

    function automatic int filled_count();
        if (rd_pos == wr_pos)
            return is_full ? ring_size : 0;
        if (wr_pos > rd_pos)
            return wr_pos - rd_pos;
        return wr_pos + ring_size - rd_pos;
    endfunction

    function automatic int smallest_of(input int a, input int b, input int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    task automatic report_mismatch(input string line);
        $display("%0t: %s", $time, line);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [CAP_W-1:0] got,
                               input logic [CAP_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic apply_capacity(input logic [CAP_W-1:0] value);
        int v;
        v = value;
        if (v == 0)
            v = 1;
        if (v > int'(MAX_CAPACITY))
            v = int'(MAX_CAPACITY);
        ring_size = v;
        rd_pos = 0;
        wr_pos = 0;
        is_full = 1'b0;
    endtask

    task automatic predict_word(input logic [2:0] op, input logic [LEN_W-1:0] len_in,
                                output ring_result_t outcome);
        int len;
        int avail;
        int room;
        len = len_in;
        avail = filled_count();
        room = ring_size - avail;
        outcome = '0;
        outcome.status = ST_OK;
        case (op)
            OP_REQ_READ:
            begin
                if (len == 0)
                    outcome.status = ST_ZERO_LENGTH;
                else if (is_stopped)
                    outcome.status = ST_TERMINATED;
                else if (avail == 0)
                    outcome.status = ST_WOULD_BLOCK;
                else
                begin
                    outcome.granted = LEN_W'(smallest_of(avail, ring_size - rd_pos, len));
                    outcome.chunk_offset = PTR_W'(rd_pos);
                end
            end
            OP_COMMIT_READ:
            begin
                if (len != 0 && avail < len)
                    outcome.status = ST_OVERRUN;
                else if (len != 0)
                begin
                    rd_pos = (rd_pos + len) % ring_size;
                    is_full = 1'b0;
                end
            end
            OP_REQ_WRITE:
            begin
                if (len == 0)
                    outcome.status = ST_ZERO_LENGTH;
                else if (is_stopped)
                    outcome.status = ST_TERMINATED;
                else if (room == 0)
                    outcome.status = ST_WOULD_BLOCK;
                else
                begin
                    outcome.granted = LEN_W'(smallest_of(room, ring_size - wr_pos, len));
                    outcome.chunk_offset = PTR_W'(wr_pos);
                end
            end
            OP_COMMIT_WRITE:
            begin
                if (len != 0 && room < len)
                    outcome.status = ST_OVERRUN;
                else if (len != 0)
                begin
                    wr_pos = (wr_pos + len) % ring_size;
                    is_full = (room == len);
                end
            end
            OP_TERMINATE:
                is_stopped = 1'b1;
            default:
                ;
        endcase
        avail = filled_count();
        outcome.bytes_available = CAP_W'(avail);
        outcome.bytes_free = CAP_W'(ring_size - avail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apply_capacity(MAX_CAPACITY);
            is_stopped = 1'b0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result word arrived with no prediction outstanding");
                else
                begin
                    oldest_outcome = pending_results.pop_front();
                    check_field("status", CAP_W'(status), CAP_W'(oldest_outcome.status));
                    check_field("chunk_offset", CAP_W'(chunk_offset),
                                CAP_W'(oldest_outcome.chunk_offset));
                    check_field("granted", granted, oldest_outcome.granted);
                    check_field("bytes_available", bytes_available,
                                oldest_outcome.bytes_available);
                    check_field("bytes_free", bytes_free, oldest_outcome.bytes_free);
                end
            end
            if (cfg_write_en)
                apply_capacity(cfg_write_data);
            if (item_valid && !item_stall)
            begin
                predict_word(req_type, length, fresh_outcome);
                pending_results.push_back(fresh_outcome);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== test/ring_buffer_chunk_reserve_commit_tb.sv =====
// Testbench top for the ring pointer manager: clock, reset, configuration writes, word stimulus
// with bursts, gaps and receiver stalls, and the final verdict.
// Depends on rbcr_pkg, ring_buffer_chunk_reserve_commit and ring_buffer_chunk_reserve_commit_checker.
module ring_buffer_chunk_reserve_commit_tb;
    import rbcr_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [CAP_W-1:0] cfg_write_data;
    logic             item_valid;
    logic             item_stall;
    logic [2:0]       req_type;
    logic [LEN_W-1:0] length;
    logic             result_valid;
    logic             result_stall;
    logic [2:0]       status;
    logic [PTR_W-1:0] chunk_offset;
    logic [LEN_W-1:0] granted;
    logic [CAP_W-1:0] bytes_available;
    logic [CAP_W-1:0] bytes_free;
    int               mismatches;
    int               outstanding;

    int   ring_size_now;
    int   burst_left;
    int   gap_max;
    logic hold_request;
    logic hold_done;
    int   phase_sizes[10] = '{1, 0, 2, 5, 17, 100, 65536, 131071, 4096, 3};

    ring_buffer_chunk_reserve_commit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .req_type        (req_type),
        .length          (length),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .chunk_offset    (chunk_offset),
        .granted         (granted),
        .bytes_available (bytes_available),
        .bytes_free      (bytes_free)
    );

    ring_buffer_chunk_reserve_commit_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .req_type        (req_type),
        .length          (length),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .chunk_offset    (chunk_offset),
        .granted         (granted),
        .bytes_available (bytes_available),
        .bytes_free      (bytes_free),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver changes its stall pattern after each run of random length, and once holds off for a
    // long stretch so that the block fills up and stalls its input.
    initial
    begin
        int stall_mode;
        int stall_run;
        int tick;
        stall_mode = 0;
        stall_run = 0;
        tick = 0;
        hold_done = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request && !hold_done)
            begin
                result_stall = 1'b1;
                repeat (64) @(negedge clk);
                hold_done = 1'b1;
                result_stall = 1'b0;
            end
            else
            begin
                if (stall_run == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stall_run = $urandom_range(20, 120);
                end
                stall_run--;
                case (stall_mode)
                    0: result_stall = 1'b0;
                    1: result_stall = ($urandom_range(0, 99) < 30);
                    2: result_stall = (tick % 4 == 0);
                    default: result_stall = ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    task automatic offer_word(input logic [2:0] op, input int len);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_valid = 1'b1;
        req_type = op;
        length = LEN_W'(len);
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain_ring();
        item_valid = 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_capacity(input int value);
        drain_ring();
        cfg_write_en = 1'b1;
        cfg_write_data = CAP_W'(value);
        @(negedge clk);
        cfg_write_en = 1'b0;
        ring_size_now = (value == 0) ? 1 : ((value > int'(MAX_CAPACITY)) ? int'(MAX_CAPACITY) : value);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 9)
            return int'(MAX_CAPACITY);
        if (r < 14)
            return (ring_size_now < int'(MAX_CAPACITY)) ? ring_size_now + 1 : ring_size_now;
        if (r < 20)
            return ring_size_now;
        if (r < 60)
            return $urandom_range(1, (ring_size_now + 3) / 4);
        return $urandom_range(1, ring_size_now);
    endfunction

    // Most words come as a request followed by a commit of the same or a shorter length.
    task automatic random_words(input int count, input bit allow_stop);
        int sent;
        int r;
        int len;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            len = pick_length();
            if (r < 60)
            begin
                offer_word((r < 32) ? OP_REQ_WRITE : OP_REQ_READ, len);
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(0, len);
                offer_word((r < 32) ? OP_COMMIT_WRITE : OP_COMMIT_READ, len);
                sent += 2;
            end
            else
            begin
                pick = $urandom_range(0, allow_stop ? 9 : 8);
                case (pick)
                    0, 1: offer_word(OP_REQ_READ, len);
                    2, 3: offer_word(OP_COMMIT_READ, len);
                    4, 5: offer_word(OP_REQ_WRITE, len);
                    6, 7: offer_word(OP_COMMIT_WRITE, len);
                    8: offer_word(3'(int'(OP_TERMINATE) + $urandom_range(1, 3)), len);
                    default: offer_word(OP_TERMINATE, len);
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        item_valid = 1'b0;
        req_type = OP_REQ_READ;
        length = '0;
        hold_request = 1'b0;
        burst_left = 0;
        gap_max = 4;
        ring_size_now = int'(MAX_CAPACITY);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty and full edges, wrap-limited grants and unused codes on the reset capacity.
        offer_word(OP_REQ_READ, 0);
        offer_word(OP_REQ_READ, 5);
        offer_word(OP_COMMIT_READ, 1);
        offer_word(OP_COMMIT_READ, 0);
        offer_word(OP_REQ_WRITE, 65536);
        offer_word(OP_COMMIT_WRITE, 65536);
        offer_word(OP_REQ_WRITE, 1);
        offer_word(OP_COMMIT_WRITE, 1);
        offer_word(OP_REQ_READ, 65536);
        offer_word(OP_COMMIT_READ, 65535);
        offer_word(OP_REQ_READ, 7);
        offer_word(OP_COMMIT_READ, 1);
        offer_word(OP_COMMIT_WRITE, 40000);
        offer_word(OP_COMMIT_READ, 40000);
        offer_word(OP_REQ_WRITE, 65536);
        offer_word(OP_COMMIT_WRITE, 30000);
        offer_word(OP_REQ_READ, 65536);
        offer_word(OP_REQ_WRITE, 65536);
        offer_word(3'(int'(OP_TERMINATE) + 1), 65536);
        offer_word(3'(int'(OP_TERMINATE) + 2), 3);
        offer_word(3'(int'(OP_TERMINATE) + 3), 0);
        random_words(40, 1'b0);

        for (int p = 0; p < 10; p++)
        begin
            set_capacity(phase_sizes[p]);
            gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
            if (p == 3)
                hold_request = 1'b1;
            if (p == 5)
            begin
                random_words(25, 1'b0);
                drain_ring();
                random_words(30, 1'b0);
            end
            else
                random_words(55, 1'b0);
        end

        // Terminate is sticky until reset, so it is only exercised in the last phase.
        set_capacity(64);
        gap_max = 4;
        offer_word(OP_COMMIT_WRITE, 10);
        offer_word(OP_TERMINATE, 0);
        offer_word(OP_REQ_READ, 0);
        offer_word(OP_REQ_READ, 3);
        offer_word(OP_REQ_WRITE, 5);
        offer_word(OP_COMMIT_WRITE, 4);
        offer_word(OP_COMMIT_READ, 14);
        offer_word(OP_REQ_WRITE, 0);
        random_words(40, 1'b1);

        drain_ring();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
